// ===== src/ansi_text_terminal_defines.svh =====
// Assertion macros shared by the terminal checker.
`ifndef ANSI_TEXT_TERMINAL_DEFINES_SVH
`define ANSI_TEXT_TERMINAL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ATT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ansi_text_terminal check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ATT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ansi_text_terminal check failed");

`endif

// ===== src/att_pkg.sv =====
// Types, byte codes and color table of the text terminal.
package att_pkg;

	typedef enum logic [3:0] {
		CL_OTHER,
		CL_DIGIT,
		CL_SEMI,
		CL_LBRACK,
		CL_ESC,
		CL_CR,
		CL_LF,
		CL_BS,
		CL_TAB,
		CL_READ
	} cls_t;

	typedef struct packed {
		cls_t        cls;
		logic        printable;
		logic [7:0]  chr;
	} item_info_t;

	typedef enum logic [1:0] {
		PM_NORMAL,
		PM_ESC,
		PM_SEQ
	} pmode_t;

	typedef enum logic [2:0] {
		B_INIT,
		B_IDLE,
		B_RD,
		B_SGR,
		B_SCR_RD,
		B_SCR_WR,
		B_FILL,
		B_DONE
	} bstate_t;

	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_UP     = 8'h41;
	localparam logic [7:0] CH_DOWN   = 8'h42;
	localparam logic [7:0] CH_RIGHT  = 8'h43;
	localparam logic [7:0] CH_LEFT   = 8'h44;
	localparam logic [7:0] CH_POS_H  = 8'h48;
	localparam logic [7:0] CH_ERASE_J = 8'h4A;
	localparam logic [7:0] CH_ERASE_K = 8'h4B;
	localparam logic [7:0] CH_POS_F  = 8'h66;
	localparam logic [7:0] CH_SGR_M  = 8'h6D;

	localparam logic [15:0] RESET_CELL = 16'h0720;
	localparam logic [7:0]  RESET_ATTR = 8'h07;
	localparam logic [3:0]  FG_DEFAULT = 4'h7;
	localparam logic [3:0]  BG_DEFAULT = 4'h0;
	localparam int          TAB_STOP   = 8;
	localparam int          DEC_BASE   = 10;

	localparam int SGR_RESET     = 0;
	localparam int SGR_BOLD      = 1;
	localparam int SGR_FAINT     = 2;
	localparam int SGR_NORMAL    = 22;
	localparam int SGR_FG_LO     = 30;
	localparam int SGR_FG_HI     = 37;
	localparam int SGR_FG_DEF    = 39;
	localparam int SGR_BG_LO     = 40;
	localparam int SGR_BG_HI     = 47;
	localparam int SGR_BG_DEF    = 49;
	localparam int SGR_FG_BRT_LO = 90;
	localparam int SGR_FG_BRT_HI = 97;
	localparam int SGR_BG_BRT_LO = 100;
	localparam int SGR_BG_BRT_HI = 107;

	// ANSI color order to text-mode color order: swap red and blue.
	function automatic logic [2:0] color_map(input logic [2:0] ansi);
		return {ansi[0], ansi[1], ansi[2]};
	endfunction

endpackage

// ===== src/att_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module att_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/att_front.sv =====
// Input side: classifies each item and holds it in a two-entry queue.
module att_front import att_pkg::*; #(
	parameter int AW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          req_type,
	input  logic [7:0]    char_byte,
	input  logic [AW-1:0] cell_index,
	input  logic          back_ready,
	output logic          q_valid,
	output item_info_t    q_info,
	output logic [AW-1:0] q_idx,
	input  logic          q_pop
);

	item_info_t    info_q [2];
	logic [AW-1:0] idx_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	item_info_t    cls_info;
	logic          push;

	always_comb begin
		cls_info.chr = char_byte;
		cls_info.printable = char_byte >= CH_SPACE;
		priority if (req_type) begin
			cls_info.cls = CL_READ;
		end else if (char_byte >= CH_ZERO && char_byte <= CH_NINE) begin
			cls_info.cls = CL_DIGIT;
		end else if (char_byte == CH_SEMI) begin
			cls_info.cls = CL_SEMI;
		end else if (char_byte == CH_LBRACK) begin
			cls_info.cls = CL_LBRACK;
		end else if (char_byte == CH_ESC) begin
			cls_info.cls = CL_ESC;
		end else if (char_byte == CH_CR) begin
			cls_info.cls = CL_CR;
		end else if (char_byte == CH_LF) begin
			cls_info.cls = CL_LF;
		end else if (char_byte == CH_BS) begin
			cls_info.cls = CL_BS;
		end else if (char_byte == CH_TAB) begin
			cls_info.cls = CL_TAB;
		end else begin
			cls_info.cls = CL_OTHER;
		end
	end

	// Hold off while the screen clear after reset runs or the queue is full.
	assign in_stall = !back_ready || (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;

	assign q_valid = cnt_q != 2'd0;
	assign q_info = info_q[rp_q];
	assign q_idx = idx_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			info_q[wp_q] <= cls_info;
			idx_q[wp_q] <= cell_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (q_pop) begin
				rp_q <= !rp_q;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (q_pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== src/att_back.sv =====
// Execution side: escape parser, cursor, attributes and screen memory sequencer.
module att_back import att_pkg::*; #(
	parameter int COLS = 80,
	parameter int ROWS = 25,
	parameter int MAX_PARAMS = 8,
	parameter int PARAM_BITS = 16,
	localparam int AW = $clog2(ROWS * COLS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  item_info_t    q_info,
	input  logic [AW-1:0] q_idx,
	output logic          q_pop,
	output logic          back_ready,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [AW-1:0] cursor_pos,
	output logic [15:0]   cell_data,
	output logic [7:0]    current_attr
);

	localparam int CELLS = ROWS * COLS;
	localparam int CW = $clog2(COLS);
	localparam int RW = $clog2(ROWS);
	localparam int PIW = $clog2(MAX_PARAMS);
	localparam int TW = CW + 4;
	localparam int NW = PARAM_BITS + 1;
	localparam int VW = PARAM_BITS + 4;

	bstate_t state_q, state_d;
	pmode_t  mode_q, mode_d;
	logic [RW-1:0] row_q, row_d;
	logic [CW-1:0] col_q, col_d;
	logic [3:0] fg_q, fg_d, bg_q, bg_d;
	logic bold_q, bold_d;
	logic [7:0] attr_q, attr_d;
	logic [PARAM_BITS-1:0] prm_q [MAX_PARAMS];
	logic [PARAM_BITS-1:0] prm_d [MAX_PARAMS];
	logic [PIW-1:0] pidx_q, pidx_d;
	logic seen_q, seen_d;
	logic [PIW-1:0] sgr_q, sgr_d, sgr_last_q, sgr_last_d;
	logic [AW-1:0] addr_q, addr_d, end_q, end_d;
	logic [15:0] cell_q, cell_d;
	logic inrange_q, inrange_d;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [15:0]   ram_wdata, ram_rdata;

	logic take, is_read, norm_byte, seq_byte, fin;
	logic nl, need_scroll, do_sgr, do_j, do_k, out_free;
	logic col_last, row_last, tab_wrap;
	logic [TW-1:0] tab_col;
	logic [AW-1:0] row_base, cur_pos;
	logic [PIW-1:0] p_sel;
	logic [PARAM_BITS-1:0] prm_cur, p0, p1, mv_n, r_sel, c_sel;
	logic [VW-1:0] dig_v;
	logic [NW-1:0] mv_sum;
	logic [15:0] blank;
	logic [3:0] sgr_fg, sgr_bg, fg_eff;
	logic sgr_bold;

	att_ram #(.WIDTH(16), .DEPTH(CELLS)) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign take = (state_q == B_IDLE) && q_valid;
	assign q_pop = take;
	assign back_ready = state_q != B_INIT;
	assign is_read = q_info.cls == CL_READ;
	assign norm_byte = take && !is_read && (mode_q == PM_NORMAL);
	assign seq_byte = take && !is_read && (mode_q == PM_SEQ);
	assign fin = seq_byte && (q_info.cls != CL_DIGIT) && (q_info.cls != CL_SEMI);

	assign p_sel = (state_q == B_SGR) ? sgr_q : pidx_q;
	assign prm_cur = prm_q[p_sel];
	assign p0 = prm_q[0];
	assign p1 = prm_q[1];

	assign row_base = AW'(row_q) * AW'(COLS);
	assign cur_pos = row_base + AW'(col_q);
	assign blank = {attr_q, CH_SPACE};
	assign col_last = col_q == CW'(COLS - 1);
	assign row_last = row_q == RW'(ROWS - 1);
	assign tab_col = (TW'(col_q) + TW'(TAB_STOP)) & ~TW'(TAB_STOP - 1);
	assign tab_wrap = tab_col >= TW'(COLS);

	assign nl = norm_byte && ((q_info.cls == CL_LF) ||
		((q_info.cls == CL_TAB) && tab_wrap) ||
		(q_info.printable && col_last));
	assign need_scroll = nl && row_last;
	assign do_sgr = fin && (q_info.chr == CH_SGR_M);
	assign do_j = fin && (q_info.chr == CH_ERASE_J) &&
		((p0 == PARAM_BITS'(2)) || !seen_q);
	assign do_k = fin && (q_info.chr == CH_ERASE_K);
	assign out_free = !out_valid || !out_stall;

	// Move count, and the 1-based home position taken to 0-based.
	assign mv_n = seen_q ? p0 : PARAM_BITS'(1);
	assign r_sel = (p0 != '0) ? p0 - PARAM_BITS'(1) : '0;
	assign c_sel = ((pidx_q != '0) && (p1 != '0)) ? p1 - PARAM_BITS'(1) : '0;
	assign dig_v = VW'(prm_cur) * VW'(DEC_BASE) + VW'(q_info.chr[3:0]);

	// One SGR code per cycle.
	always_comb begin
		sgr_fg = fg_q;
		sgr_bg = bg_q;
		sgr_bold = bold_q;
		if (prm_cur == PARAM_BITS'(SGR_RESET)) begin
			sgr_fg = FG_DEFAULT;
			sgr_bg = BG_DEFAULT;
			sgr_bold = 1'b0;
		end else if (prm_cur == PARAM_BITS'(SGR_BOLD)) begin
			sgr_bold = 1'b1;
		end else if (prm_cur == PARAM_BITS'(SGR_FAINT) ||
				prm_cur == PARAM_BITS'(SGR_NORMAL)) begin
			sgr_bold = 1'b0;
		end else if (prm_cur >= PARAM_BITS'(SGR_FG_LO) &&
				prm_cur <= PARAM_BITS'(SGR_FG_HI)) begin
			sgr_fg = {1'b0, color_map(3'(prm_cur - PARAM_BITS'(SGR_FG_LO)))};
		end else if (prm_cur == PARAM_BITS'(SGR_FG_DEF)) begin
			sgr_fg = FG_DEFAULT;
		end else if (prm_cur >= PARAM_BITS'(SGR_BG_LO) &&
				prm_cur <= PARAM_BITS'(SGR_BG_HI)) begin
			sgr_bg = {1'b0, color_map(3'(prm_cur - PARAM_BITS'(SGR_BG_LO)))};
		end else if (prm_cur == PARAM_BITS'(SGR_BG_DEF)) begin
			sgr_bg = BG_DEFAULT;
		end else if (prm_cur >= PARAM_BITS'(SGR_FG_BRT_LO) &&
				prm_cur <= PARAM_BITS'(SGR_FG_BRT_HI)) begin
			sgr_fg = {1'b1, color_map(3'(prm_cur - PARAM_BITS'(SGR_FG_BRT_LO)))};
		end else if (prm_cur >= PARAM_BITS'(SGR_BG_BRT_LO) &&
				prm_cur <= PARAM_BITS'(SGR_BG_BRT_HI)) begin
			sgr_bg = {1'b1, color_map(3'(prm_cur - PARAM_BITS'(SGR_BG_BRT_LO)))};
		end
		fg_eff = sgr_fg;
		if (sgr_bold) begin
			fg_eff[3] = 1'b1;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_INIT: begin
				if (addr_q == AW'(CELLS - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (take) begin
					if (is_read) begin
						state_d = B_RD;
					end else if (do_sgr) begin
						state_d = B_SGR;
					end else if (do_j || do_k) begin
						state_d = B_FILL;
					end else if (need_scroll) begin
						state_d = B_SCR_RD;
					end else begin
						state_d = B_DONE;
					end
				end
			end
			B_RD: state_d = B_DONE;
			B_SGR: begin
				if (sgr_q == sgr_last_q) begin
					state_d = B_DONE;
				end
			end
			B_SCR_RD: state_d = B_SCR_WR;
			B_SCR_WR: begin
				state_d = (addr_q == AW'(CELLS - COLS - 1)) ? B_FILL : B_SCR_RD;
			end
			B_FILL: begin
				if (addr_q == end_q) begin
					state_d = B_DONE;
				end
			end
			B_DONE: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Register updates and memory control.
	always_comb begin
		mode_d = mode_q;
		row_d = row_q;
		col_d = col_q;
		fg_d = fg_q;
		bg_d = bg_q;
		bold_d = bold_q;
		attr_d = attr_q;
		prm_d = prm_q;
		pidx_d = pidx_q;
		seen_d = seen_q;
		sgr_d = sgr_q;
		sgr_last_d = sgr_last_q;
		addr_d = addr_q;
		end_d = end_q;
		cell_d = cell_q;
		inrange_d = inrange_q;
		ram_we = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = blank;
		ram_raddr = q_idx;
		mv_sum = '0;
		unique case (state_q)
			B_INIT: begin
				ram_we = 1'b1;
				ram_wdata = RESET_CELL;
				addr_d = (addr_q == AW'(CELLS - 1)) ? '0 : addr_q + AW'(1);
			end
			B_IDLE: begin
				if (take) begin
					cell_d = '0;
					if (is_read) begin
						inrange_d = (AW + 1)'(q_idx) < (AW + 1)'(CELLS);
					end else begin
						unique case (mode_q)
							PM_ESC: begin
								if (q_info.cls == CL_LBRACK) begin
									mode_d = PM_SEQ;
									pidx_d = '0;
									seen_d = 1'b0;
									for (int i = 0; i < MAX_PARAMS; i++) begin
										prm_d[i] = '0;
									end
								end else begin
									mode_d = PM_NORMAL;
								end
							end
							PM_SEQ: begin
								if (q_info.cls == CL_DIGIT) begin
									prm_d[pidx_q] = (dig_v > VW'({PARAM_BITS{1'b1}})) ?
										{PARAM_BITS{1'b1}} : PARAM_BITS'(dig_v);
									seen_d = 1'b1;
								end else if (q_info.cls == CL_SEMI) begin
									if (pidx_q < PIW'(MAX_PARAMS - 1)) begin
										pidx_d = pidx_q + PIW'(1);
										prm_d[PIW'(pidx_q + PIW'(1))] = '0;
									end
								end else begin
									mode_d = PM_NORMAL;
									sgr_d = '0;
									sgr_last_d = seen_q ? pidx_q : '0;
									if (do_j) begin
										row_d = '0;
										col_d = '0;
										addr_d = '0;
										end_d = AW'(CELLS - 1);
									end else if (do_k) begin
										addr_d = row_base;
										end_d = row_base + AW'(COLS - 1);
									end else if (q_info.chr == CH_POS_H ||
											q_info.chr == CH_POS_F) begin
										row_d = (r_sel >= PARAM_BITS'(ROWS)) ?
											RW'(ROWS - 1) : RW'(r_sel);
										col_d = (c_sel >= PARAM_BITS'(COLS)) ?
											CW'(COLS - 1) : CW'(c_sel);
									end else if (q_info.chr == CH_LEFT) begin
										col_d = (NW'(col_q) >= NW'(mv_n)) ?
											CW'(NW'(col_q) - NW'(mv_n)) : '0;
									end else if (q_info.chr == CH_RIGHT) begin
										mv_sum = NW'(col_q) + NW'(mv_n);
										col_d = (mv_sum >= NW'(COLS)) ?
											CW'(COLS - 1) : CW'(mv_sum);
									end else if (q_info.chr == CH_UP) begin
										row_d = (NW'(row_q) >= NW'(mv_n)) ?
											RW'(NW'(row_q) - NW'(mv_n)) : '0;
									end else if (q_info.chr == CH_DOWN) begin
										mv_sum = NW'(row_q) + NW'(mv_n);
										row_d = (mv_sum >= NW'(ROWS)) ?
											RW'(ROWS - 1) : RW'(mv_sum);
									end
								end
							end
							PM_NORMAL: begin
								if (q_info.cls == CL_ESC) begin
									mode_d = PM_ESC;
								end else if (q_info.cls == CL_CR) begin
									col_d = '0;
								end else if (q_info.cls == CL_BS) begin
									if (col_q != '0) begin
										col_d = col_q - CW'(1);
										ram_we = 1'b1;
										ram_waddr = cur_pos - AW'(1);
									end
								end else if (q_info.cls == CL_TAB) begin
									if (!tab_wrap) begin
										col_d = CW'(tab_col);
									end
								end else if (q_info.printable) begin
									ram_we = 1'b1;
									ram_waddr = cur_pos;
									ram_wdata = {attr_q, q_info.chr};
									col_d = col_q + CW'(1);
								end
								// Line feed, tab past the end or wrap after the last column.
								if (nl) begin
									col_d = '0;
									row_d = row_last ? row_q : row_q + RW'(1);
									addr_d = '0;
								end
							end
							default: mode_d = PM_NORMAL;
						endcase
					end
				end
			end
			B_RD: begin
				cell_d = inrange_q ? ram_rdata : '0;
			end
			B_SGR: begin
				fg_d = sgr_fg;
				bg_d = sgr_bg;
				bold_d = sgr_bold;
				sgr_d = sgr_q + PIW'(1);
				if (sgr_q == sgr_last_q) begin
					attr_d = {sgr_bg, fg_eff};
				end
			end
			B_SCR_RD: begin
				ram_raddr = addr_q + AW'(COLS);
			end
			B_SCR_WR: begin
				// Copy one cell up a row; the last row is blanked after.
				ram_we = 1'b1;
				ram_wdata = ram_rdata;
				addr_d = addr_q + AW'(1);
				end_d = AW'(CELLS - 1);
			end
			B_FILL: begin
				ram_we = 1'b1;
				addr_d = addr_q + AW'(1);
			end
			B_DONE: begin
				cell_d = cell_q;
			end
			default: begin
				cell_d = cell_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		cell_q <= cell_d;
		inrange_q <= inrange_d;
		end_q <= end_d;
		if (state_q == B_DONE && out_free) begin
			cursor_pos <= cur_pos;
			cell_data <= cell_q;
			current_attr <= attr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
			mode_q <= PM_NORMAL;
			row_q <= '0;
			col_q <= '0;
			fg_q <= FG_DEFAULT;
			bg_q <= BG_DEFAULT;
			bold_q <= 1'b0;
			attr_q <= RESET_ATTR;
			for (int i = 0; i < MAX_PARAMS; i++) begin
				prm_q[i] <= '0;
			end
			pidx_q <= '0;
			seen_q <= 1'b0;
			sgr_q <= '0;
			sgr_last_q <= '0;
			addr_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q <= mode_d;
			row_q <= row_d;
			col_q <= col_d;
			fg_q <= fg_d;
			bg_q <= bg_d;
			bold_q <= bold_d;
			attr_q <= attr_d;
			prm_q <= prm_d;
			pidx_q <= pidx_d;
			seen_q <= seen_d;
			sgr_q <= sgr_d;
			sgr_last_q <= sgr_last_d;
			addr_q <= addr_d;
			if (state_q == B_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

// ===== src/ansi_text_terminal.sv =====
// Top level of the ANSI text terminal: input queue, executor and screen memory.
// A byte item, a cell read and an SGR each end in a result; an SGR steps through its parameters.
// Erase display and erase line fill the screen or the row, both one memory write a cycle.
// A scroll reads and writes each cell to move it up a row, then blanks the last row.
// After reset a clearing pass fills the screen; in_stall stays high meanwhile.
module ansi_text_terminal import att_pkg::*; #(
	parameter int COLS = 80,
	parameter int ROWS = 25,
	parameter int MAX_PARAMS = 8,
	parameter int PARAM_BITS = 16,
	localparam int AW = $clog2(ROWS * COLS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          req_type,
	input  logic [7:0]    char_byte,
	input  logic [AW-1:0] cell_index,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [AW-1:0] cursor_pos,
	output logic [15:0]   cell_data,
	output logic [7:0]    current_attr
);

	logic          q_valid;
	item_info_t    q_info;
	logic [AW-1:0] q_idx;
	logic          q_pop;
	logic          back_ready;

	att_front #(.AW(AW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.char_byte  (char_byte),
		.cell_index (cell_index),
		.back_ready (back_ready),
		.q_valid    (q_valid),
		.q_info     (q_info),
		.q_idx      (q_idx),
		.q_pop      (q_pop)
	);

	att_back #(
		.COLS       (COLS),
		.ROWS       (ROWS),
		.MAX_PARAMS (MAX_PARAMS),
		.PARAM_BITS (PARAM_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_info       (q_info),
		.q_idx        (q_idx),
		.q_pop        (q_pop),
		.back_ready   (back_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cursor_pos   (cursor_pos),
		.cell_data    (cell_data),
		.current_attr (current_attr)
	);

endmodule

// ===== src/att_checker.sv =====
// Port-level checker for the terminal and its bind to the top level.
`include "ansi_text_terminal_defines.svh"

module att_checker #(
	parameter int AW = 11,
	parameter int CELLS = 2000
) (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input logic [AW-1:0] cursor_pos,
	input logic [15:0]   cell_data,
	input logic [7:0]    current_attr
);

	// Items accepted whose result has not been taken yet.
	logic [2:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(in_valid && !in_stall) - 3'(out_valid && !out_stall);
		end
	end

	`ATT_ASSERT_NOW(a_pos_on_screen, out_valid, (AW + 1)'(cursor_pos) < (AW + 1)'(CELLS))
	`ATT_ASSERT_NOW(a_no_invented_result, out_valid, pend_q != 3'd0)
	`ATT_ASSERT_NOW(a_pending_bounded, 1'b1, pend_q <= 3'd4)
	`ATT_ASSERT_NEXT(a_stalled_result_holds, out_valid && out_stall, out_valid && $stable(cursor_pos) && $stable(cell_data) && $stable(current_attr))

endmodule

bind ansi_text_terminal att_checker #(.AW(AW), .CELLS(ROWS * COLS)) u_att_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.cursor_pos   (cursor_pos),
	.cell_data    (cell_data),
	.current_attr (current_attr)
);

// ===== tb/att_checker.sv =====
// Scoreboard of the text terminal: predicts every result from the accepted items and compares.
module att_scoreboard import att_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  char_byte,
	input  logic [10:0] cell_index,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [10:0] cursor_pos,
	input  logic [15:0] cell_data,
	input  logic [7:0]  current_attr,
	output int          fail_count,
	output int          pending_count,
	output int          result_count
);
	localparam int NCOLS = 80;
	localparam int NROWS = 25;
	localparam int NCELLS = NCOLS * NROWS;
	localparam int NPARAMS = 8;
	localparam int PMAX = 65535;

	typedef struct packed {
		logic [10:0] pos;
		logic [15:0] data;
		logic [7:0]  attr;
	} term_result_t;

	logic [15:0] screen [NCELLS];
	int unsigned row, col, fg, bg, attr;
	logic bold, seen;
	pmode_t mode;
	int unsigned prm [NPARAMS];
	int unsigned pidx;
	term_result_t expected_q [$];

	function automatic logic [15:0] blank();
		return {attr[7:0], CH_SPACE};
	endfunction

	task automatic scroll_screen();
		for (int i = 0; i < NCELLS - NCOLS; i++) screen[i] = screen[i + NCOLS];
		for (int x = 0; x < NCOLS; x++) screen[NCELLS - NCOLS + x] = blank();
		row = NROWS - 1;
	endtask

	task automatic next_line();
		col = 0;
		row++;
		if (row >= NROWS) scroll_screen();
	endtask

	function automatic int unsigned ansi_color(int unsigned a, bit bright);
		return {bright, a[0], a[1], a[2]};
	endfunction

	task automatic run_sgr();
		int unsigned n;
		int unsigned c;
		n = seen ? pidx + 1 : 1;
		for (int i = 0; i < n; i++) begin
			c = prm[i];
			if (c == SGR_RESET) begin
				fg = FG_DEFAULT; bg = BG_DEFAULT; bold = 0;
			end else if (c == SGR_BOLD) bold = 1;
			else if (c == SGR_FAINT || c == SGR_NORMAL) bold = 0;
			else if (c >= SGR_FG_LO && c <= SGR_FG_HI) fg = ansi_color(c - SGR_FG_LO, 0);
			else if (c == SGR_FG_DEF) fg = FG_DEFAULT;
			else if (c >= SGR_BG_LO && c <= SGR_BG_HI) bg = ansi_color(c - SGR_BG_LO, 0);
			else if (c == SGR_BG_DEF) bg = BG_DEFAULT;
			else if (c >= SGR_FG_BRT_LO && c <= SGR_FG_BRT_HI)
				fg = ansi_color(c - SGR_FG_BRT_LO, 1);
			else if (c >= SGR_BG_BRT_LO && c <= SGR_BG_BRT_HI)
				bg = ansi_color(c - SGR_BG_BRT_LO, 1);
		end
		attr = (bg << 4) | ((bold && fg < 8) ? (fg | 8) : fg);
	endtask

	task automatic end_sequence(logic [7:0] b);
		int unsigned n;
		int unsigned r, c;
		n = seen ? prm[0] : 1;
		case (b)
			CH_SGR_M: run_sgr();
			CH_ERASE_J: if (prm[0] == 2 || !seen) begin
				row = 0; col = 0;
				for (int i = 0; i < NCELLS; i++) screen[i] = blank();
			end
			CH_ERASE_K: for (int x = 0; x < NCOLS; x++) screen[row * NCOLS + x] = blank();
			CH_POS_H, CH_POS_F: if (!seen) begin
				row = 0; col = 0;
			end else begin
				r = prm[0] > 0 ? prm[0] - 1 : 0;
				c = (pidx > 0 && prm[1] > 0) ? prm[1] - 1 : 0;
				row = r >= NROWS ? NROWS - 1 : r;
				col = c >= NCOLS ? NCOLS - 1 : c;
			end
			CH_LEFT:  col = col >= n ? col - n : 0;
			CH_RIGHT: col = col + n >= NCOLS ? NCOLS - 1 : col + n;
			CH_UP:    row = row >= n ? row - n : 0;
			CH_DOWN:  row = row + n >= NROWS ? NROWS - 1 : row + n;
			default: ;
		endcase
		mode = PM_NORMAL;
	endtask

	task automatic feed_byte(logic [7:0] b);
		int unsigned v;
		if (mode == PM_ESC) begin
			if (b == CH_LBRACK) begin
				mode = PM_SEQ; pidx = 0; seen = 0;
				for (int i = 0; i < NPARAMS; i++) prm[i] = 0;
			end else mode = PM_NORMAL;
		end else if (mode == PM_SEQ) begin
			if (b >= CH_ZERO && b <= CH_NINE) begin
				v = prm[pidx] * DEC_BASE + (b - CH_ZERO);
				prm[pidx] = v > PMAX ? PMAX : v;
				seen = 1;
			end else if (b == CH_SEMI) begin
				if (pidx < NPARAMS - 1) begin
					pidx++; prm[pidx] = 0;
				end
			end else end_sequence(b);
		end else begin
			case (b)
				CH_ESC: mode = PM_ESC;
				CH_CR: col = 0;
				CH_LF: next_line();
				CH_BS: if (col > 0) begin
					col--; screen[row * NCOLS + col] = blank();
				end
				CH_TAB: begin
					col = (col + TAB_STOP) & ~(TAB_STOP - 1);
					if (col >= NCOLS) next_line();
				end
				default: if (b >= CH_SPACE) begin
					screen[row * NCOLS + col] = {attr[7:0], b};
					col++;
					if (col >= NCOLS) next_line();
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		term_result_t e;
		if (!arst_n) begin
			for (int i = 0; i < NCELLS; i++) screen[i] = RESET_CELL;
			row = 0; col = 0; fg = FG_DEFAULT; bg = BG_DEFAULT; bold = 0;
			attr = RESET_ATTR; mode = PM_NORMAL; pidx = 0; seen = 0;
			for (int i = 0; i < NPARAMS; i++) prm[i] = 0;
			expected_q.delete();
			fail_count = 0; result_count = 0; pending_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				result_count++;
				if (expected_q.size() == 0) begin
					$error("unexpected result pos=%0d", cursor_pos);
					fail_count++;
				end else begin
					e = expected_q.pop_front();
					if (cursor_pos !== e.pos) begin
						$error("cursor_pos exp %0d got %0d", e.pos, cursor_pos);
						fail_count++;
					end
					if (cell_data !== e.data) begin
						$error("cell_data exp %h got %h", e.data, cell_data);
						fail_count++;
					end
					if (current_attr !== e.attr) begin
						$error("current_attr exp %h got %h", e.attr, current_attr);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				e.data = '0;
				if (req_type) begin
					if (cell_index < NCELLS) e.data = screen[cell_index];
				end else feed_byte(char_byte);
				e.pos = 11'(row * NCOLS + col);
				e.attr = attr[7:0];
				expected_q.push_back(e);
			end
			pending_count = expected_q.size();
		end
	end
endmodule

// ===== tb/tb_top.sv =====
// Stimulus and verdict for the text terminal test.
module tb_top import att_pkg::*;;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, req_type = 0, out_stall = 0;
	logic [7:0] char_byte = 0;
	logic [10:0] cell_index = 0;
	logic in_stall, out_valid;
	logic [10:0] cursor_pos;
	logic [15:0] cell_data;
	logic [7:0] current_attr;
	int fail_count, pending_count, result_count;
	int idle_cycles = 0;
	bit hold_mode = 0;
	bit stall_long = 0;
	bit done = 0;
	int sent = 0, reads = 0, seqs = 0;

	localparam int WATCHDOG = 200000;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	ansi_text_terminal u_dut (
		.clk, .arst_n, .in_valid, .in_stall, .req_type, .char_byte, .cell_index,
		.out_valid, .out_stall, .cursor_pos, .cell_data, .current_attr
	);

	att_scoreboard u_chk (
		.clk, .arst_n, .in_valid, .in_stall, .req_type, .char_byte, .cell_index,
		.out_valid, .out_stall, .cursor_pos, .cell_data, .current_attr,
		.fail_count, .pending_count, .result_count
	);

	// Receiver stall pattern; a long hold when requested.
	always @(posedge clk) begin
		if (stall_long) out_stall <= 1;
		else if (hold_mode) out_stall <= 0;
		else out_stall <= ($urandom_range(0, 3) == 0);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send(logic rt, logic [7:0] b, logic [10:0] idx);
		in_valid <= 1;
		req_type <= rt;
		char_byte <= b;
		cell_index <= idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		if (rt) reads++;
	endtask

	task automatic gap();
		int n;
		n = hold_mode ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
		if (n > 0) begin
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic put(logic [7:0] b);
		send(0, b, 11'($urandom));
		gap();
	endtask

	task automatic read_cell(logic [10:0] idx);
		send(1, 8'($urandom), idx);
		gap();
	endtask

	task automatic csi(string s);
		seqs++;
		put(CH_ESC);
		put(CH_LBRACK);
		for (int i = 0; i < s.len(); i++) put(s[i]);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	// Random well-formed sequence with random parameters.
	task automatic random_csi();
		string s;
		int np;
		logic [7:0] finals [10];
		logic [7:0] fb;
		finals = '{CH_SGR_M, CH_ERASE_J, CH_ERASE_K, CH_POS_H, CH_POS_F,
			CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT, "z"};
		s = "";
		np = $urandom_range(0, 3);
		for (int i = 0; i < np; i++) begin
			if (i > 0) s = {s, ";"};
			case ($urandom_range(0, 4))
				0: s = {s, $sformatf("%0d", $urandom_range(0, 9))};
				1: s = {s, $sformatf("%0d", $urandom_range(30, 49))};
				2: s = {s, $sformatf("%0d", $urandom_range(90, 107))};
				3: s = {s, $sformatf("%0d", $urandom_range(0, 99))};
				default: ;
			endcase
		end
		// erase display is slow; keep it rare
		fb = finals[$urandom_range(0, 9)];
		if (fb == CH_ERASE_J && $urandom_range(0, 7) != 0) fb = CH_SGR_M;
		s = {s, $sformatf("%c", fb)};
		csi(s);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed part
		put("A"); put(8'hFF); put(CH_TAB); put(CH_BS); put(CH_CR);
		put(8'h00); put(8'h07);
		csi("1;31;44m"); put("B");
		csi("5;70H"); csi("B"); csi("0C"); csi("99999D"); csi("A");
		csi("2K"); csi("0;0f"); csi("1;2;3;4;5;6;7;8;9;97;107m");
		put(CH_ESC); put("x");
		csi("q"); csi("3J");
		read_cell(0); read_cell(1); read_cell(11'd1999); read_cell(11'd2047);
		csi("25;80H"); put(CH_LF); put("Z");
		csi("J"); csi("0m");
		drain();
		// long receiver hold while the sender keeps offering items
		fork
			begin
				stall_long = 1;
				repeat (300) @(posedge clk);
				stall_long = 0;
			end
			begin
				hold_mode = 1;
				for (int i = 0; i < 20; i++) put(8'("a" + i));
				hold_mode = 0;
			end
		join
		drain();
		// random part
		while (sent < 430) begin
			case ($urandom_range(0, 9))
				0, 1, 2: random_csi();
				3: read_cell(11'($urandom_range(0, 2047)));
				4: put(8'($urandom_range(0, 31)));
				5: begin
					put(CH_ESC);
					put(8'($urandom));
				end
				default: put(8'($urandom_range(32, 255)));
			endcase
			if ($urandom_range(0, 40) == 0) drain();
		end
		for (int i = 0; i < 8; i++) read_cell(11'($urandom_range(0, 1999)));
		drain();
		done = 1;
		repeat (200) @(posedge clk);
		$display("Sent %0d items (%0d cell reads, %0d control sequences), %0d results checked.",
			sent, reads, seqs, result_count);
		if (fail_count == 0 && pending_count == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
